FILE: hdl/spe_pkg.sv
`timescale 1ns / 1ps
package spe_pkg;
  localparam int LineBytesDef = 32;
  localparam logic [7:0] WhiteByte = 8'hff;
  localparam logic [7:0] PadByte = 8'h80;
  localparam int BandRows = 388;
  localparam int MaxLiteral = 127;
  localparam int MaxFill = 128;
  localparam logic [7:0] FillBase = 8'd1;

  typedef struct packed {
    logic clear_fill;
    logic scan_l;
    logic scan_r;
    logic setup;
    logic emit;
  } spe_cmd_t;

  typedef struct packed {
    logic empty;
    logic l_done;
    logic r_done;
    logic all_white;
    logic emit_done;
  } spe_sts_t;
endpackage

FILE: hdl/spe_datapath.sv
`timescale 1ns / 1ps
module spe_datapath #(
  parameter int LINE_BYTES = spe_pkg::LineBytesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [7:0]          wr_byte,
  input  logic [15:0]         row_index,
  input  logic [15:0]         origin_x,
  input  logic [15:0]         origin_y,
  input  spe_pkg::spe_cmd_t   cmd,
  output spe_pkg::spe_sts_t   sts,
  output logic                out_valid,
  output logic [7:0]          out_packed_byte,
  output logic                out_last_of_line,
  output logic [16:0]         out_start_x,
  output logic [16:0]         out_row_y,
  output logic signed [7:0]   out_row_bytes,
  output logic [6:0]          out_packed_length,
  output logic                out_band_break
);
  import spe_pkg::*;

  localparam int IW = $clog2(LINE_BYTES);
  localparam int CW = $clog2(LINE_BYTES + 1);
  localparam int NW = 8;
  localparam int BandShift = 26;
  localparam logic [17:0] BandRecip =
    18'(((64'd1 << BandShift) + 64'(BandRows) - 64'd1) / 64'(BandRows));

  logic [7:0]    mem [LINE_BYTES];
  logic [CW-1:0] fill_r;
  logic [CW-1:0] l_r, r_r, len_r;
  logic [16:0]   prev_y_r;
  logic          rev_r;
  logic [16:0]   ypos;
  logic [16:0]   ypos_r;

  // span buffer (pre-ordered)
  logic [7:0]    span_r [LINE_BYTES];
  logic [CW-1:0] m_r;

  // encoder state
  typedef enum logic [2:0] {
    E_IDLE, E_SCAN, E_LITH, E_LIT, E_FILLH, E_FILLB, E_PAD
  } enc_t;
  enc_t          es_r;
  logic [CW-1:0] s_r, p_r, nxt_r, k_r;
  logic [NW-1:0] n_r, padded_r;

  // band number by reciprocal multiply, exact for 17-bit rows
  function automatic logic [8:0] band_of(input logic [16:0] v);
    logic [34:0] prod;
    prod = 35'(v) * 35'(BandRecip);
    return prod[BandShift+8:BandShift];
  endfunction

  assign ypos = 17'(origin_y) + 17'(row_index);

  // forward looking: first triple from p
  logic trip;
  always_comb begin
    trip = 1'b0;
    if (32'(p_r) + 2 < 32'(m_r))
      trip = (span_r[p_r[IW-1:0]] == span_r[IW'(p_r + 1'b1)]) &&
             (span_r[p_r[IW-1:0]] == span_r[IW'(p_r + 2'd2)]);
  end

  always_ff @(posedge clk) begin
    if (wr_en && 32'(fill_r) < LINE_BYTES) mem[fill_r[IW-1:0]] <= wr_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      prev_y_r <= '0;
      rev_r    <= 1'b0;
      es_r     <= E_IDLE;
    end else begin
      if (wr_en && 32'(fill_r) < LINE_BYTES) fill_r <= fill_r + 1'b1;
      if (cmd.clear_fill) begin
        fill_r <= '0;
        len_r  <= fill_r;
        l_r    <= '0;
        ypos_r <= ypos;
      end
      if (cmd.scan_l && !sts.l_done) l_r <= l_r + 1'b1;
      if (cmd.scan_l && sts.l_done) r_r <= len_r;
      if (cmd.scan_r && !sts.r_done) r_r <= r_r - 1'b1;
      if (cmd.setup) begin
        for (int i = 0; i < LINE_BYTES; i++)
          if (rev_r) span_r[i] <= mem[IW'(r_r - 1'b1 - CW'(i))];
          else       span_r[i] <= mem[IW'(l_r + CW'(i))];
        m_r <= r_r - l_r;
        out_start_x <= 17'(origin_x) + 17'({l_r, 3'd0});
        out_row_y <= ypos_r;
        out_band_break <= band_of(ypos_r) != band_of(prev_y_r);
        prev_y_r <= ypos_r;
        out_row_bytes <= rev_r ? -8'(r_r - l_r) : 8'(r_r - l_r);
        rev_r <= !rev_r;
      end
      if (cmd.emit && es_r == E_IDLE) begin
        es_r <= E_SCAN; s_r <= '0; p_r <= '0; n_r <= '0;
        // packed length upper bound computed below at pad time
      end
      case (es_r)
        E_IDLE: ;
        E_SCAN: begin
          if (s_r == m_r) begin
            es_r <= E_PAD; padded_r <= (n_r + 8'd7) & 8'hf8;
            out_packed_length <= 7'((n_r + 8'd7) & 8'hf8);
          end else if (trip && p_r == s_r) begin
            es_r <= E_FILLH;
          end else if (trip || 32'(p_r) + 2 >= 32'(m_r)) begin
            nxt_r <= trip ? p_r : m_r; es_r <= E_LITH;
          end else p_r <= p_r + 1'b1;
        end
        E_LITH: begin
          k_r <= (32'(nxt_r - s_r) > MaxLiteral) ? CW'(MaxLiteral) : nxt_r - s_r;
          es_r <= E_LIT; n_r <= n_r + 1'b1;
        end
        E_LIT: begin
          n_r <= n_r + 1'b1; s_r <= s_r + 1'b1; k_r <= k_r - 1'b1;
          if (k_r == 1) begin
            if (s_r + 1'b1 == nxt_r) begin es_r <= E_SCAN; p_r <= nxt_r; end
            else es_r <= E_LITH;
          end
        end
        E_FILLH: begin
          if (32'(p_r) + 1 < 32'(m_r) &&
              span_r[p_r[IW-1:0]] == span_r[IW'(p_r + 1'b1)]) p_r <= p_r + 1'b1;
          else begin es_r <= E_FILLB; n_r <= n_r + 8'd2; end
        end
        E_FILLB: begin
          es_r <= E_SCAN; s_r <= p_r + 1'b1; p_r <= p_r + 1'b1;
        end
        E_PAD: ;
        default: es_r <= E_IDLE;
      endcase
      if (es_r == E_PAD) es_r <= E_IDLE;
    end
  end

  // second pass: emit stream sequentially, regenerated deterministically
  typedef enum logic [2:0] {
    G_IDLE, G_SCAN, G_LITH, G_LIT, G_FH, G_FB, G_PAD
  } gen_t;
  gen_t          gs_r;
  logic [CW-1:0] gs_s_r, gs_p_r, gs_nxt_r, gs_k_r, gs_q_r;
  logic [NW-1:0] cnt_r;
  logic          gtrip;
  logic          g_done_r;
  logic          fh_ext;
  logic          g_put;

  always_comb begin
    gtrip = 1'b0;
    if (32'(gs_p_r) + 2 < 32'(m_r))
      gtrip = (span_r[gs_p_r[IW-1:0]] == span_r[IW'(gs_p_r + 1'b1)]) &&
              (span_r[gs_p_r[IW-1:0]] == span_r[IW'(gs_p_r + 2'd2)]);
  end

  // run continues past p
  assign fh_ext = (32'(gs_p_r) + 1 < 32'(m_r)) &&
                  (span_r[gs_p_r[IW-1:0]] == span_r[IW'(gs_p_r + 1'b1)]);

  always_comb begin
    case (gs_r)
      G_LITH, G_LIT, G_FB: g_put = 1'b1;
      G_FH:                g_put = !fh_ext;
      G_PAD:               g_put = (cnt_r != padded_r);
      default:             g_put = 1'b0;
    endcase
  end

  task automatic put(input logic [7:0] b);
    out_packed_byte <= b;
    out_last_of_line <= (cnt_r + 1'b1 == padded_r);
    cnt_r <= cnt_r + 1'b1;
  endtask

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r <= G_IDLE; g_done_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      out_valid <= g_put;
      g_done_r <= (gs_r == G_PAD) && (cnt_r == padded_r);
      case (gs_r)
        G_IDLE: if (es_r == E_PAD) begin
          gs_r <= G_SCAN; gs_s_r <= '0; gs_p_r <= '0; cnt_r <= '0;
        end
        G_SCAN: begin
          if (gs_s_r == m_r) gs_r <= G_PAD;
          else if (gtrip && gs_p_r == gs_s_r) begin
            gs_r <= G_FH; gs_q_r <= gs_p_r;
          end else if (gtrip || 32'(gs_p_r) + 2 >= 32'(m_r)) begin
            gs_nxt_r <= gtrip ? gs_p_r : m_r; gs_r <= G_LITH;
          end else gs_p_r <= gs_p_r + 1'b1;
        end
        G_LITH: begin
          gs_k_r <= gs_nxt_r - gs_s_r;
          put(8'(gs_nxt_r - gs_s_r) - 8'd1);
          gs_r <= G_LIT;
        end
        G_LIT: begin
          put(~span_r[gs_s_r[IW-1:0]]);
          gs_s_r <= gs_s_r + 1'b1; gs_k_r <= gs_k_r - 1'b1;
          if (gs_k_r == 1) begin gs_r <= G_SCAN; gs_p_r <= gs_nxt_r; end
        end
        G_FH: begin
          if (fh_ext) gs_p_r <= gs_p_r + 1'b1;
          else begin
            put(8'(9'd257 - 9'(gs_p_r - gs_q_r + 1'b1)));
            gs_r <= G_FB;
          end
        end
        G_FB: begin
          put(~span_r[gs_p_r[IW-1:0]]);
          gs_s_r <= gs_p_r + 1'b1; gs_p_r <= gs_p_r + 1'b1; gs_r <= G_SCAN;
        end
        G_PAD: begin
          if (cnt_r == padded_r) gs_r <= G_IDLE;
          else put(PadByte);
        end
        default: gs_r <= G_IDLE;
      endcase
    end
  end

  assign sts.empty     = (fill_r == '0);
  assign sts.l_done    = (l_r >= len_r) || (mem[l_r[IW-1:0]] != WhiteByte);
  assign sts.all_white = (l_r >= len_r);
  assign sts.r_done    = (r_r - 1'b1 <= l_r) || (mem[IW'(r_r - 1'b1)] != WhiteByte);
  assign sts.emit_done = g_done_r;
endmodule

FILE: hdl/spe_ctrl.sv
`timescale 1ns / 1ps
module spe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              eol,
  input  spe_pkg::spe_sts_t sts,
  output spe_pkg::spe_cmd_t cmd,
  output logic              busy
);
  import spe_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_L, S_R, S_SET, S_EMIT, S_WAIT} state_t;
  state_t state_r;

  always_comb begin
    cmd = '0;
    cmd.clear_fill = eol && state_r == S_IDLE;
    cmd.scan_l = state_r == S_L;
    cmd.scan_r = state_r == S_R;
    cmd.setup  = state_r == S_SET;
    cmd.emit   = state_r == S_EMIT;
  end

  assign busy = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (eol) state_r <= S_L;
        S_L: if (sts.l_done) state_r <= sts.all_white ? S_IDLE : S_R;
        S_R: if (sts.r_done) state_r <= S_SET;
        S_SET: state_r <= S_EMIT;
        S_EMIT: state_r <= S_WAIT;
        S_WAIT: if (sts.emit_done) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/scanline_packbits_encoder_top.sv
`timescale 1ns / 1ps
// Scanline PackBits encoder.
// Input: command port. An item is taken when start is high and busy low.
// in_req_type 0 appends in_pixel_byte to the line store with busy
// staying low, so appends may follow back to back; bytes beyond LINE_BYTES are
// dropped. 1 ends the line and encodes it, with busy high throughout.
// End of line: white bytes are trimmed from the left, then the right, and
// the setup state loads the span. A sizing pass then walks the span to find
// the packed length, and the emission pass walks it again, adding 0x80 pad
// bytes, one result per out_valid strobe, padded to a multiple of eight.
// busy falls after the last byte, via the registered emit_done; an empty or
// all-white line drops busy after the left scan and gives no results.
// The receiver cannot stall: each result is valid for one cycle only.
// Config: APB writes to origin_x (0x0) and origin_y (0x4) while idle.
// Reset clears fill count, previous row, line direction and origins.
module scanline_packbits_encoder_top #(
  parameter int LINE_BYTES = spe_pkg::LineBytesDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_req_type,
  input  logic [7:0]        in_pixel_byte,
  input  logic [15:0]       in_row_index,
  output logic              out_valid,
  output logic [7:0]        out_packed_byte,
  output logic              out_last_of_line,
  output logic [16:0]       out_start_x,
  output logic [16:0]       out_row_y,
  output logic signed [7:0] out_row_bytes,
  output logic [6:0]        out_packed_length,
  output logic              out_band_break,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import spe_pkg::*;

  logic [15:0] ox_r, oy_r;
  spe_cmd_t cmd;
  spe_sts_t sts;
  logic acc, ctl_busy;

  assign pready = 1'b1;
  assign acc = start && !busy;
  assign busy = ctl_busy;
  assign prdata = (paddr == 3'd0) ? {16'd0, ox_r} : (paddr == 3'd4) ? {16'd0, oy_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0; oy_r <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'd0) ox_r <= pwdata[15:0];
      if (paddr == 3'd4) oy_r <= pwdata[15:0];
    end
  end

  spe_ctrl u_ctrl (.clk, .rst_n, .eol(acc && in_req_type), .sts, .cmd, .busy(ctl_busy));

  spe_datapath #(.LINE_BYTES(LINE_BYTES)) u_dp (
    .clk, .rst_n, .wr_en(acc && !in_req_type), .wr_byte(in_pixel_byte),
    .row_index(in_row_index), .origin_x(ox_r), .origin_y(oy_r), .cmd, .sts,
    .out_valid, .out_packed_byte, .out_last_of_line, .out_start_x, .out_row_y,
    .out_row_bytes, .out_packed_length, .out_band_break
  );
endmodule

FILE: dv/spe_line_checker.sv
`timescale 1ns / 1ps
module spe_line_checker #(
  parameter int LINE_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_req_type,
  input  logic [7:0]        in_pixel_byte,
  input  logic [15:0]       in_row_index,
  input  logic              out_valid,
  input  logic [7:0]        out_packed_byte,
  input  logic              out_last_of_line,
  input  logic [16:0]       out_start_x,
  input  logic [16:0]       out_row_y,
  input  logic signed [7:0] out_row_bytes,
  input  logic [6:0]        out_packed_length,
  input  logic              out_band_break,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending_bytes,
  output int                lines_coded
);
  import spe_pkg::*;

  localparam logic [2:0] AddrOriginX = 3'h0;
  localparam logic [2:0] AddrOriginY = 3'h4;

  typedef struct packed {
    logic [7:0]        pbyte;
    logic              last;
    logic [16:0]       sx;
    logic [16:0]       ry;
    logic signed [7:0] rbytes;
    logic [6:0]        plen;
    logic              band;
  } packed_out_t;

  packed_out_t      expected_bytes[$];
  logic [7:0]       line_buf[LINE_BYTES];
  int               line_fill;
  logic [16:0]      prev_row;
  logic             reverse_line;
  logic [15:0]      org_x;
  logic [15:0]      org_y;

  assign pending_bytes = expected_bytes.size();

  task automatic encode_line(input logic [15:0] row);
    logic [7:0]  span[LINE_BYTES];
    logic [7:0]  pk[$];
    int          l, r, m, s, nxt, p, q, k, padded;
    logic [16:0] ypos;
    logic        band;
    packed_out_t o;
    l = 0;
    while (l < line_fill && line_buf[l] == WhiteByte) l++;
    if (l >= line_fill) begin
      line_fill = 0;
      return;
    end
    r = line_fill - 1;
    while (r > l && line_buf[r] == WhiteByte) r--;
    r++;
    m = r - l;
    line_fill = 0;
    for (int i = 0; i < m; i++) span[i] = reverse_line ? line_buf[r - 1 - i] : line_buf[l + i];
    ypos = 17'(org_y) + 17'(row);
    band = (int'(ypos) / BandRows) != (int'(prev_row) / BandRows);
    prev_row = ypos;
    o.rbytes = reverse_line ? -8'(m) : 8'(m);
    reverse_line = !reverse_line;
    s = 0;
    while (s < m) begin
      nxt = m;
      for (p = s; p + 2 < m; p++)
        if (span[p] == span[p + 1] && span[p] == span[p + 2]) begin
          nxt = p;
          break;
        end
      while (s < nxt) begin
        k = (nxt - s > MaxLiteral) ? MaxLiteral : nxt - s;
        pk.push_back(8'(k - 1));
        for (int i = 0; i < k; i++) begin
          pk.push_back(~span[s]);
          s++;
        end
      end
      if (nxt < m) begin
        p = nxt;
        q = nxt;
        while (p + 1 < m && span[p] == span[p + 1]) p++;
        while (q <= p) begin
          k = (p - q + 1 > MaxFill) ? MaxFill : p - q + 1;
          pk.push_back(8'(257 - k));
          pk.push_back(~span[p]);
          q += k;
        end
        s = p + 1;
      end
    end
    padded = (pk.size() + 7) / 8 * 8;
    while (pk.size() < padded) pk.push_back(PadByte);
    if (padded > 64) padded = 64;
    for (int i = 0; i < padded; i++) begin
      o.pbyte = pk[i];
      o.last  = (i + 1 == padded);
      o.sx    = 17'(org_x) + 17'(8 * l);
      o.ry    = ypos;
      o.plen  = 7'(padded);
      o.band  = band;
      expected_bytes.push_back(o);
    end
    lines_coded++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      line_fill    = 0;
      prev_row     = '0;
      reverse_line = 1'b0;
      org_x        <= '0;
      org_y        <= '0;
      fail_count   = 0;
      lines_coded  = 0;
      expected_bytes.delete();
    end else begin
      if (out_valid) begin
        packed_out_t e;
        if (expected_bytes.size() == 0) begin
          $error("packed byte %0h with nothing expected", out_packed_byte);
          fail_count++;
        end else begin
          e = expected_bytes.pop_front();
          if (out_packed_byte !== e.pbyte) begin
            $error("packed_byte exp %0h got %0h", e.pbyte, out_packed_byte);
            fail_count++;
          end
          if (out_last_of_line !== e.last) begin
            $error("last_of_line exp %0d got %0d", e.last, out_last_of_line);
            fail_count++;
          end
          if (out_start_x !== e.sx) begin
            $error("start_x exp %0d got %0d", e.sx, out_start_x);
            fail_count++;
          end
          if (out_row_y !== e.ry) begin
            $error("row_y exp %0d got %0d", e.ry, out_row_y);
            fail_count++;
          end
          if (out_row_bytes !== e.rbytes) begin
            $error("row_bytes exp %0d got %0d", e.rbytes, out_row_bytes);
            fail_count++;
          end
          if (out_packed_length !== e.plen) begin
            $error("packed_length exp %0d got %0d", e.plen, out_packed_length);
            fail_count++;
          end
          if (out_band_break !== e.band) begin
            $error("band_break exp %0d got %0d", e.band, out_band_break);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (in_req_type == 1'b0) begin
          if (line_fill < LINE_BYTES) begin
            line_buf[line_fill] = in_pixel_byte;
            line_fill = line_fill + 1;
          end
        end else begin
          encode_line(in_row_index);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == AddrOriginX) org_x <= pwdata[15:0];
        else if (paddr == AddrOriginY) org_y <= pwdata[15:0];
      end
    end
  end
endmodule

FILE: dv/scanline_packbits_encoder_top_tb.sv
`timescale 1ns / 1ps
module scanline_packbits_encoder_top_tb;
  import spe_pkg::*;

  localparam int LineCap = LineBytesDef;
  localparam logic [2:0] AddrOriginX = 3'h0;
  localparam logic [2:0] AddrOriginY = 3'h4;
  localparam logic       ReqAppend = 1'b0;
  localparam logic       ReqEnd = 1'b1;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_req_type;
  logic [7:0]        in_pixel_byte;
  logic [15:0]       in_row_index;
  logic              out_valid;
  logic [7:0]        out_packed_byte;
  logic              out_last_of_line;
  logic [16:0]       out_start_x;
  logic [16:0]       out_row_y;
  logic signed [7:0] out_row_bytes;
  logic [6:0]        out_packed_length;
  logic              out_band_break;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                pending_bytes;
  int                lines_coded;
  int                items_sent;
  int                gap_left;

  scanline_packbits_encoder_top #(.LINE_BYTES(LineCap)) u_dut (.*);

  spe_line_checker #(.LINE_BYTES(LineCap)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_item(input logic req, input logic [7:0] pix, input logic [15:0] row);
    if (gap_left == 0 && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 12);
    while (gap_left > 0) begin
      start <= 1'b0;
      @(posedge clk);
      gap_left--;
    end
    start         <= 1'b1;
    in_req_type   <= req;
    in_pixel_byte <= pix;
    in_row_index  <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_bytes != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_line(input logic [7:0] bytes[$], input logic [15:0] row);
    foreach (bytes[i]) send_item(ReqAppend, bytes[i], 16'(1 + $urandom_range(0, 9)));
    send_item(ReqEnd, 8'(1 + $urandom_range(0, 9)), row);
  endtask

  task automatic random_line(input logic [15:0] row);
    logic [7:0] bytes[$];
    int         n, mode, runlen;
    logic [7:0] v;
    n = $urandom_range(0, 9) == 0 ? $urandom_range(LineCap, LineCap + 4) : $urandom_range(0, 20);
    mode = $urandom_range(0, 3);
    while (bytes.size() < n) begin
      v = (mode == 0) ? 8'($urandom) : 8'($urandom_range(0, 3) == 0 ? 8'hff : $urandom_range(0, 3));
      runlen = $urandom_range(1, 6);
      for (int i = 0; i < runlen && bytes.size() < n; i++) bytes.push_back(v);
    end
    send_line(bytes, row);
  endtask

  initial begin
    logic [7:0] d[$];
    logic [15:0] row;
    start = 1'b0;
    in_req_type = ReqAppend;
    in_pixel_byte = '0;
    in_row_index = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    gap_left = 0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty, all white, literals, fills, overflow, extremes
    send_item(ReqEnd, 8'h00, 16'd5);
    d = '{8'hff, 8'hff};
    send_line(d, 16'd1);
    d = '{8'hff, 8'h00, 8'h12, 8'h34, 8'hff};
    send_line(d, 16'd0);
    d = '{8'h55, 8'h55, 8'h55, 8'h55, 8'h01};
    send_line(d, 16'hffff);
    d = {};
    for (int i = 0; i < LineCap + 3; i++) d.push_back(8'h7f);
    send_line(d, 16'd400);
    drain();
    write_reg(AddrOriginX, 32'h0000_ffff);
    write_reg(AddrOriginY, 32'h0000_ffff);
    d = {};
    for (int i = 0; i < LineCap; i++) d.push_back(8'(i * 37));
    send_line(d, 16'hffff);
    d = '{8'hff, 8'h80, 8'haa, 8'haa};
    send_line(d, 16'd0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(AddrOriginX, ph == 1 ? 32'h0 : 32'($urandom_range(0, 65535)));
      write_reg(AddrOriginY, ph == 1 ? 32'h0 : 32'($urandom_range(0, 65535)));
      row = 16'($urandom);
      while (items_sent < 170 + ph * 85) begin
        row = row + 16'($urandom_range(0, 400));
        random_line(row);
      end
      drain();
    end

    $display("Sent %0d items; %0d lines coded over directed cases and 4 random phases.",
             items_sent, lines_coded);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hdl/spe_pkg.sv
hdl/spe_datapath.sv
hdl/spe_ctrl.sv
hdl/scanline_packbits_encoder_top.sv
dv/spe_line_checker.sv
dv/scanline_packbits_encoder_top_tb.sv
